>>> rtl/scope_packet_deframer_rotary_decode_assert.svh
// Assertion macros for the packet deframer.
// Expects signals named clock and reset in the module that uses them.
`ifndef SCOPE_PACKET_DEFRAMER_ROTARY_DECODE_ASSERT_SVH
`define SCOPE_PACKET_DEFRAMER_ROTARY_DECODE_ASSERT_SVH

// same-cycle implication
`define SPDRD_ASSERT_IMPL(label, ante, cons) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error("spdrd assertion failed");

// next-cycle implication
`define SPDRD_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error("spdrd assertion failed");

`endif

>>> rtl/spdrd_pkg.sv
// Shared types, constants and the encoder pattern function of the deframer.
// No dependencies.
package spdrd_pkg;

   localparam int MID_DEPTH = 2;
   localparam int OUT_DEPTH = 4;

   localparam int RAW_W    = 14;
   localparam int MV_W     = 15;
   localparam int DIG_W    = 4;
   localparam int POS_W    = 4;
   localparam int NUM_ENC  = 3;
   localparam int HIST_LEN = 4;

   localparam logic [7:0] SYNC_RESET = 8'd115;
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_NINE = 8'h39;

   localparam logic [POS_W-1:0] POS_HUNT      = 4'd0;
   localparam logic [POS_W-1:0] POS_FIRST     = 4'd1;
   localparam logic [POS_W-1:0] POS_CH1_LAST  = 4'd4;
   localparam logic [POS_W-1:0] POS_CH2_LAST  = 4'd8;
   localparam logic [POS_W-1:0] POS_ENC_FIRST = 4'd9;
   localparam logic [POS_W-1:0] POS_ENC_LAST  = 4'd11;

   // volts_mv = MV_OFFSET - (raw * VOLT_SCALE + VOLT_ROUND) / VOLT_DIV
   localparam int NUM_W       = 27;
   localparam int RECIP_W     = 15;
   localparam int PROD_W      = NUM_W + RECIP_W;
   localparam int RECIP_SHIFT = 27;
   localparam int VOLT_SCALE  = 13200;
   localparam int VOLT_ROUND  = 4095;
   localparam int VOLT_DIV    = 8190;
   localparam int RECIP       = (1 << RECIP_SHIFT) / VOLT_DIV;
   localparam int MV_OFFSET   = 3325;

   typedef enum logic [1:0] {
      ENC_NONE = 2'd0,
      ENC_CW   = 2'd1,
      ENC_CCW  = 2'd2
   } enc_event_type;

   typedef logic [DIG_W-1:0] digit_type;
   // element HIST_LEN-1 is the newest phase
   typedef digit_type [HIST_LEN-1:0] hist_type;

   localparam hist_type HIST_RESET = 16'h0123;
   localparam hist_type CW_A  = 16'h3201;
   localparam hist_type CW_B  = 16'h2013;
   localparam hist_type CW_C  = 16'h0132;
   localparam hist_type CW_D  = 16'h1320;
   localparam hist_type CCW_A = 16'h2310;
   localparam hist_type CCW_B = 16'h3102;
   localparam hist_type CCW_C = 16'h1023;
   localparam hist_type CCW_D = 16'h0231;

   typedef struct packed {
      logic                   malformed;
      logic [RAW_W-1:0]       raw_ch1;
      logic [RAW_W-1:0]       raw_ch2;
      digit_type [NUM_ENC-1:0] enc;
      digit_type              sw;
   } pkt_type;

   typedef struct packed {
      logic [RAW_W-1:0]           raw_ch1;
      logic [RAW_W-1:0]           raw_ch2;
      logic signed [MV_W-1:0]     mv_ch1;
      logic signed [MV_W-1:0]     mv_ch2;
      enc_event_type [NUM_ENC-1:0] ev;
      digit_type                  sw;
      logic                       sw_changed;
      logic                       malformed;
   } rsp_type;

   function automatic enc_event_type enc_event(input hist_type h);
      enc_event_type ev;
      case (h)
         CW_A, CW_B, CW_C, CW_D:     ev = ENC_CW;
         CCW_A, CCW_B, CCW_C, CCW_D: ev = ENC_CCW;
         default:                    ev = ENC_NONE;
      endcase
      return ev;
   endfunction

endpackage

>>> rtl/scope_packet_deframer_rotary_decode.sv
// Top level of the scope packet deframer with rotary encoder decode.
// Depends on spdrd_pkg, spdrd_front, spdrd_queue and spdrd_back.
//
// Input channel: one byte per push, taken when push is high and full is low.
// The front end hunts for csr_wdata's sync character (reset 's'), then takes
// twelve ASCII digits: two 4-digit readings, three encoder phases, a switch.
// Result channel: a result is on the rsp_ ports while empty is low and is
// taken when pop is high. One result per packet, or one per malformed byte.
// Throughput: one byte per clock while full is low; the front end never waits on the math.
// Path: a packet goes through the packet queue, the encoder/switch stage, the
// reciprocal multiply stage and the result queue before it shows on the ports.
// Voltage is 3325 - round(raw * 6600 / 4095) mV, done with one multiply by a
// fixed reciprocal and a single correction step.
// When the receiver stalls, results wait in a 4-deep result queue and then
// in the 2-deep packet queue; full rises only when the packet queue is full.
// Reset clears the hunt, the encoder histories and the switch state and
// reloads the sync character; both queues come up empty.
module scope_packet_deframer_rotary_decode #(
   parameter int MID_DEPTH = spdrd_pkg::MID_DEPTH,
   parameter int OUT_DEPTH = spdrd_pkg::OUT_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [7:0]                         csr_wdata,
   input  logic                               push,
   output logic                               full,
   input  logic [7:0]                         req_data_byte,
   output logic                               empty,
   input  logic                               pop,
   output logic [spdrd_pkg::RAW_W-1:0]        rsp_raw_ch1,
   output logic [spdrd_pkg::RAW_W-1:0]        rsp_raw_ch2,
   output logic signed [spdrd_pkg::MV_W-1:0]  rsp_volts_ch1_mv,
   output logic signed [spdrd_pkg::MV_W-1:0]  rsp_volts_ch2_mv,
   output logic [1:0]                         rsp_enc1_event,
   output logic [1:0]                         rsp_enc2_event,
   output logic [1:0]                         rsp_enc3_event,
   output logic [3:0]                         rsp_switch_value,
   output logic                               rsp_switch_changed,
   output logic                               rsp_malformed
);

   localparam int PKT_W   = $bits(spdrd_pkg::pkt_type);
   localparam int MCNT_W  = $clog2(MID_DEPTH + 1);

   logic               byte_valid;
   logic               front_push;
   spdrd_pkg::pkt_type front_pkt;
   logic [PKT_W-1:0]   mid_dout;
   logic               mid_empty;
   logic               mid_pop;
   logic [MCNT_W-1:0]  mid_cnt;
   spdrd_pkg::rsp_type rsp;

   assign byte_valid = push && !full;

   spdrd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_wdata    (csr_wdata),
      .byte_valid   (byte_valid),
      .byte_data    (req_data_byte),
      .pkt_push     (front_push),
      .pkt_data     (front_pkt)
   );

   spdrd_queue #(
      .WIDTH (PKT_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .din   (front_pkt),
      .full  (full),
      .pop   (mid_pop),
      .dout  (mid_dout),
      .empty (mid_empty),
      .count (mid_cnt)
   );

   spdrd_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pkt_empty (mid_empty),
      .pkt_data  (spdrd_pkg::pkt_type'(mid_dout)),
      .pkt_pop   (mid_pop),
      .rsp_data  (rsp),
      .rsp_empty (empty),
      .rsp_pop   (pop)
   );

   assign rsp_raw_ch1        = rsp.raw_ch1;
   assign rsp_raw_ch2        = rsp.raw_ch2;
   assign rsp_volts_ch1_mv   = rsp.mv_ch1;
   assign rsp_volts_ch2_mv   = rsp.mv_ch2;
   assign rsp_enc1_event     = rsp.ev[0];
   assign rsp_enc2_event     = rsp.ev[1];
   assign rsp_enc3_event     = rsp.ev[2];
   assign rsp_switch_value   = rsp.sw;
   assign rsp_switch_changed = rsp.sw_changed;
   assign rsp_malformed      = rsp.malformed;

   `include "scope_packet_deframer_rotary_decode_assert.svh"

   `SPDRD_ASSERT_IMPL(a_mid_count_bound, 1'b1, mid_cnt <= MCNT_W'(MID_DEPTH))
   `SPDRD_ASSERT_IMPL(a_push_has_room, front_push, !full)
   `SPDRD_ASSERT_NEXT(a_pop_drains, mid_pop && !front_push && mid_cnt == MCNT_W'(1),
                      mid_empty)

endmodule

>>> rtl/spdrd_queue.sv
// Small first-in first-out queue of flip-flops with an occupancy count.
// No dependencies.
module spdrd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [WIDTH-1:0]               din,
   output logic                           full,
   input  logic                           pop,
   output logic [WIDTH-1:0]               dout,
   output logic                           empty,
   output logic [$clog2(DEPTH+1)-1:0]     count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push_ok, pop_ok;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign count   = cnt_ff;
   assign dout    = mem_ff[rd_ptr_ff];
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

>>> rtl/spdrd_front.sv
// Front end: sync hunt, digit check and payload collection into packets.
// Depends on spdrd_pkg.
module spdrd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic [7:0]        csr_wdata,
   input  logic              byte_valid,
   input  logic [7:0]        byte_data,
   output logic              pkt_push,
   output spdrd_pkg::pkt_type pkt_data
);

   logic [7:0]                              sync_ff;
   logic [spdrd_pkg::POS_W-1:0]             pos_ff, pos_in;
   logic [spdrd_pkg::RAW_W-1:0]             acc1_ff, acc1_in;
   logic [spdrd_pkg::RAW_W-1:0]             acc2_ff, acc2_in;
   spdrd_pkg::digit_type [spdrd_pkg::NUM_ENC-1:0] enc_ff, enc_in;
   logic                                    is_digit;
   spdrd_pkg::digit_type                    digit;
   logic [spdrd_pkg::RAW_W-1:0]             acc1_next, acc2_next;

   assign is_digit = (byte_data >= spdrd_pkg::ASCII_ZERO) &&
                     (byte_data <= spdrd_pkg::ASCII_NINE);
   assign digit    = spdrd_pkg::DIG_W'(byte_data - spdrd_pkg::ASCII_ZERO);
   assign acc1_next = spdrd_pkg::RAW_W'({acc1_ff, 3'b000} + {acc1_ff, 1'b0} + digit);
   assign acc2_next = spdrd_pkg::RAW_W'({acc2_ff, 3'b000} + {acc2_ff, 1'b0} + digit);

   always_comb begin
      pos_in   = pos_ff;
      acc1_in  = acc1_ff;
      acc2_in  = acc2_ff;
      enc_in   = enc_ff;
      pkt_push = 1'b0;
      pkt_data = '0;
      if (byte_valid) begin
         if (pos_ff == spdrd_pkg::POS_HUNT) begin
            if (byte_data == sync_ff) begin
               pos_in  = spdrd_pkg::POS_FIRST;
               acc1_in = '0;
               acc2_in = '0;
            end
         end else if (!is_digit) begin
            pkt_push           = 1'b1;
            pkt_data.malformed = 1'b1;
            pos_in             = spdrd_pkg::POS_HUNT;
            acc1_in            = '0;
            acc2_in            = '0;
         end else if (pos_ff <= spdrd_pkg::POS_CH1_LAST) begin
            acc1_in = acc1_next;
            pos_in  = pos_ff + 1'b1;
         end else if (pos_ff <= spdrd_pkg::POS_CH2_LAST) begin
            acc2_in = acc2_next;
            pos_in  = pos_ff + 1'b1;
         end else if (pos_ff <= spdrd_pkg::POS_ENC_LAST) begin
            enc_in[2'(pos_ff - spdrd_pkg::POS_ENC_FIRST)] = digit;
            pos_in = pos_ff + 1'b1;
         end else begin
            pkt_push         = 1'b1;
            pkt_data.raw_ch1 = acc1_ff;
            pkt_data.raw_ch2 = acc2_ff;
            pkt_data.enc     = enc_ff;
            pkt_data.sw      = digit;
            pos_in           = spdrd_pkg::POS_HUNT;
            acc1_in          = '0;
            acc2_in          = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= spdrd_pkg::SYNC_RESET;
         pos_ff  <= spdrd_pkg::POS_HUNT;
         acc1_ff <= '0;
         acc2_ff <= '0;
         enc_ff  <= '0;
      end else begin
         if (csr_write_en) begin
            sync_ff <= csr_wdata;
         end
         pos_ff  <= pos_in;
         acc1_ff <= acc1_in;
         acc2_ff <= acc2_in;
         enc_ff  <= enc_in;
      end
   end

endmodule

>>> rtl/spdrd_back.sv
// Back end: encoder history, switch tracking, voltage pipeline, result queue.
// Depends on spdrd_pkg, spdrd_queue and the assertion macro header.
`include "scope_packet_deframer_rotary_decode_assert.svh"

module spdrd_back #(
   parameter int OUT_DEPTH = spdrd_pkg::OUT_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pkt_empty,
   input  spdrd_pkg::pkt_type pkt_data,
   output logic               pkt_pop,
   output spdrd_pkg::rsp_type rsp_data,
   output logic               rsp_empty,
   input  logic               rsp_pop
);

   localparam int CNT_W = $clog2(OUT_DEPTH + 1);
   localparam int RSP_W = $bits(spdrd_pkg::rsp_type);

   spdrd_pkg::hist_type  hist_ff [spdrd_pkg::NUM_ENC];
   spdrd_pkg::hist_type  hist_in [spdrd_pkg::NUM_ENC];
   spdrd_pkg::digit_type sw_ff;

   logic                              v1_ff, v2_ff;
   logic [spdrd_pkg::NUM_W-1:0]       num1_s1_ff, num2_s1_ff, num1_in, num2_in;
   logic [spdrd_pkg::NUM_W-1:0]       num1_s2_ff, num2_s2_ff;
   logic [spdrd_pkg::PROD_W-1:0]      prod1_ff, prod2_ff;
   spdrd_pkg::rsp_type                s1_rsp_ff, s1_rsp_in, s2_rsp_ff, out_item;

   logic [CNT_W-1:0]                  out_cnt;
   logic                              out_full;
   logic [RSP_W-1:0]                  out_dout;
   logic [spdrd_pkg::MV_W-1:0]        q1, q2;

   assign pkt_pop = !pkt_empty &&
                    (({1'b0, out_cnt} + CNT_W'(v1_ff) + CNT_W'(v2_ff)) <
                     (CNT_W + 1)'(OUT_DEPTH));

   function automatic logic [spdrd_pkg::MV_W-1:0] quot_fix(
      input logic [spdrd_pkg::NUM_W-1:0]  num,
      input logic [spdrd_pkg::PROD_W-1:0] prod
   );
      logic [spdrd_pkg::MV_W-1:0]  q0;
      logic [spdrd_pkg::NUM_W:0]   rem;
      q0  = prod[spdrd_pkg::PROD_W-1:spdrd_pkg::RECIP_SHIFT];
      rem = {1'b0, num} - (spdrd_pkg::NUM_W + 1)'((spdrd_pkg::NUM_W + 1)'(q0) *
                                                  (spdrd_pkg::NUM_W + 1)'(spdrd_pkg::VOLT_DIV));
      return (rem >= (spdrd_pkg::NUM_W + 1)'(spdrd_pkg::VOLT_DIV)) ? q0 + 1'b1 : q0;
   endfunction

   // classify encoders and switch at issue
   always_comb begin
      s1_rsp_in           = '0;
      s1_rsp_in.raw_ch1   = pkt_data.raw_ch1;
      s1_rsp_in.raw_ch2   = pkt_data.raw_ch2;
      s1_rsp_in.malformed = pkt_data.malformed;
      for (int e = 0; e < spdrd_pkg::NUM_ENC; e++) begin
         hist_in[e] = hist_ff[e];
         if (!pkt_data.malformed &&
             pkt_data.enc[e] != hist_ff[e][spdrd_pkg::HIST_LEN-1]) begin
            hist_in[e] = {pkt_data.enc[e], hist_ff[e][spdrd_pkg::HIST_LEN-1:1]};
            s1_rsp_in.ev[e] = spdrd_pkg::enc_event(hist_in[e]);
         end
      end
      if (!pkt_data.malformed) begin
         s1_rsp_in.sw         = pkt_data.sw;
         s1_rsp_in.sw_changed = (pkt_data.sw != sw_ff);
      end
      num1_in = spdrd_pkg::NUM_W'(spdrd_pkg::NUM_W'(pkt_data.raw_ch1) *
                                  spdrd_pkg::NUM_W'(spdrd_pkg::VOLT_SCALE) +
                                  spdrd_pkg::NUM_W'(spdrd_pkg::VOLT_ROUND));
      num2_in = spdrd_pkg::NUM_W'(spdrd_pkg::NUM_W'(pkt_data.raw_ch2) *
                                  spdrd_pkg::NUM_W'(spdrd_pkg::VOLT_SCALE) +
                                  spdrd_pkg::NUM_W'(spdrd_pkg::VOLT_ROUND));
   end

   // finish the quotient and the millivolt value
   always_comb begin
      q1       = quot_fix(num1_s2_ff, prod1_ff);
      q2       = quot_fix(num2_s2_ff, prod2_ff);
      out_item = s2_rsp_ff;
      if (!s2_rsp_ff.malformed) begin
         out_item.mv_ch1 = signed'(spdrd_pkg::MV_W'(spdrd_pkg::MV_OFFSET) - q1);
         out_item.mv_ch2 = signed'(spdrd_pkg::MV_W'(spdrd_pkg::MV_OFFSET) - q2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         sw_ff <= '0;
         for (int e = 0; e < spdrd_pkg::NUM_ENC; e++) begin
            hist_ff[e] <= spdrd_pkg::HIST_RESET;
         end
      end else begin
         v1_ff <= pkt_pop;
         v2_ff <= v1_ff;
         if (pkt_pop) begin
            for (int e = 0; e < spdrd_pkg::NUM_ENC; e++) begin
               hist_ff[e] <= hist_in[e];
            end
            if (!pkt_data.malformed) begin
               sw_ff <= pkt_data.sw;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_rsp_ff  <= s1_rsp_in;
      num1_s1_ff <= num1_in;
      num2_s1_ff <= num2_in;
      s2_rsp_ff  <= s1_rsp_ff;
      num1_s2_ff <= num1_s1_ff;
      num2_s2_ff <= num2_s1_ff;
      prod1_ff   <= spdrd_pkg::PROD_W'(num1_s1_ff) * spdrd_pkg::PROD_W'(spdrd_pkg::RECIP);
      prod2_ff   <= spdrd_pkg::PROD_W'(num2_s1_ff) * spdrd_pkg::PROD_W'(spdrd_pkg::RECIP);
   end

   spdrd_queue #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (v2_ff),
      .din   (out_item),
      .full  (out_full),
      .pop   (rsp_pop),
      .dout  (out_dout),
      .empty (rsp_empty),
      .count (out_cnt)
   );

   assign rsp_data = spdrd_pkg::rsp_type'(out_dout);

   `SPDRD_ASSERT_IMPL(a_out_no_overflow, v2_ff, !out_full)
   `SPDRD_ASSERT_IMPL(a_issue_has_pkt, pkt_pop, !pkt_empty)
   `SPDRD_ASSERT_NEXT(a_issue_reaches_s1, pkt_pop, v1_ff)
   `SPDRD_ASSERT_IMPL(a_malformed_clean, v2_ff && s2_rsp_ff.malformed,
                      out_item.raw_ch1 == '0 && out_item.mv_ch1 == '0 &&
                      out_item.mv_ch2 == '0 && out_item.sw_changed == 1'b0)

endmodule

>>> dv/scope_packet_deframer_rotary_decode_tb.sv
// Testbench for scope_packet_deframer_rotary_decode: byte frames in, decoded words out.
// Predicts each decoded word from its own deframer and encoder model and checks every field.
// Depends on spdrd_pkg and the RTL of the block; nothing else.
module scope_packet_deframer_rotary_decode_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 4000;
   localparam int ERROR_PRINT_MAX = 50;

   typedef enum logic [1:0] {
      POP_STEADY,
      POP_COIN,
      POP_LONG_STALL,
      POP_SPARSE
   } pop_mode_type;

   typedef struct packed {
      logic [13:0]                                       raw_ch1;
      logic [13:0]                                       raw_ch2;
      logic signed [14:0]                                mv_ch1;
      logic signed [14:0]                                mv_ch2;
      spdrd_pkg::enc_event_type [spdrd_pkg::NUM_ENC-1:0] ev;
      logic [3:0]                                        sw;
      logic                                              sw_changed;
      logic                                              malformed;
   } decode_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_en = 1'b0;
   logic [7:0]         csr_wdata = 8'h00;
   logic               push = 1'b0;
   logic               full;
   logic [7:0]         req_data_byte = 8'h00;
   logic               empty;
   logic               pop = 1'b0;
   logic [13:0]        rsp_raw_ch1;
   logic [13:0]        rsp_raw_ch2;
   logic signed [14:0] rsp_volts_ch1_mv;
   logic signed [14:0] rsp_volts_ch2_mv;
   logic [1:0]         rsp_enc1_event;
   logic [1:0]         rsp_enc2_event;
   logic [1:0]         rsp_enc3_event;
   logic [3:0]         rsp_switch_value;
   logic               rsp_switch_changed;
   logic               rsp_malformed;

   scope_packet_deframer_rotary_decode dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_wdata          (csr_wdata),
      .push               (push),
      .full               (full),
      .req_data_byte      (req_data_byte),
      .empty              (empty),
      .pop                (pop),
      .rsp_raw_ch1        (rsp_raw_ch1),
      .rsp_raw_ch2        (rsp_raw_ch2),
      .rsp_volts_ch1_mv   (rsp_volts_ch1_mv),
      .rsp_volts_ch2_mv   (rsp_volts_ch2_mv),
      .rsp_enc1_event     (rsp_enc1_event),
      .rsp_enc2_event     (rsp_enc2_event),
      .rsp_enc3_event     (rsp_enc3_event),
      .rsp_switch_value   (rsp_switch_value),
      .rsp_switch_changed (rsp_switch_changed),
      .rsp_malformed      (rsp_malformed)
   );

   always #5 clock = ~clock;

   // deframer model state
   logic [7:0]      sync_reg;
   logic [3:0]      frame_pos;
   logic [13:0]     acc_ch1;
   logic [13:0]     acc_ch2;
   logic [3:0]      phase_digit [spdrd_pkg::NUM_ENC];
   logic [3:0]      enc_hist [spdrd_pkg::NUM_ENC][4];
   logic [3:0]      switch_state;
   decode_word_type pending_decodes [$];

   // bookkeeping
   int errors = 0;
   int bytes_sent = 0;
   int words_checked = 0;
   int malformed_seen = 0;
   int cw_steps = 0;
   int ccw_steps = 0;
   int sync_settings = 0;
   int quiet_cycles = 0;
   int burst_left = 0;
   logic [7:0] cur_sync = spdrd_pkg::SYNC_RESET;
   int walk_idx [spdrd_pkg::NUM_ENC] = '{0, 0, 0};
   int last_sw = 0;

   pop_mode_type pop_mode = POP_STEADY;
   logic [7:0]   pop_tick = 8'd0;

   task automatic report_error(input string msg);
      errors++;
      if (errors <= ERROR_PRINT_MAX)
         $display("ERROR @%0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_error($sformatf("%s got %0d expected %0d", name, $signed(got), $signed(want)));
   endtask

   function automatic logic signed [14:0] millivolts(input logic [13:0] raw);
      int q;
      q = (int'(raw) * 13200 + 4095) / 8190;
      return 15'(3325 - q);
   endfunction

   function automatic spdrd_pkg::enc_event_type step_encoder(input int e,
                                                             input logic [3:0] phase);
      int pattern;
      if (phase == enc_hist[e][0])
         return spdrd_pkg::ENC_NONE;
      for (int k = 3; k > 0; k--)
         enc_hist[e][k] = enc_hist[e][k-1];
      enc_hist[e][0] = phase;
      pattern = enc_hist[e][0] * 1000 + enc_hist[e][1] * 100 + enc_hist[e][2] * 10
              + enc_hist[e][3];
      case (pattern)
         3201, 2013, 132, 1320: return spdrd_pkg::ENC_CW;
         2310, 3102, 1023, 231: return spdrd_pkg::ENC_CCW;
         default:               return spdrd_pkg::ENC_NONE;
      endcase
   endfunction

   task automatic clear_model();
      sync_reg = spdrd_pkg::SYNC_RESET;
      frame_pos = spdrd_pkg::POS_HUNT;
      acc_ch1 = '0;
      acc_ch2 = '0;
      switch_state = '0;
      for (int e = 0; e < spdrd_pkg::NUM_ENC; e++) begin
         phase_digit[e] = '0;
         for (int k = 0; k < 4; k++)
            enc_hist[e][k] = 4'(k);
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      decode_word_type w;
      logic [3:0]      d;
      w = '0;
      d = 4'(b - spdrd_pkg::ASCII_ZERO);
      if (frame_pos == spdrd_pkg::POS_HUNT) begin
         if (b == sync_reg) begin
            frame_pos = spdrd_pkg::POS_FIRST;
            acc_ch1 = '0;
            acc_ch2 = '0;
         end
      end else if (b < spdrd_pkg::ASCII_ZERO || b > spdrd_pkg::ASCII_NINE) begin
         w.malformed = 1'b1;
         pending_decodes.push_back(w);
         malformed_seen++;
         frame_pos = spdrd_pkg::POS_HUNT;
         acc_ch1 = '0;
         acc_ch2 = '0;
      end else if (frame_pos <= spdrd_pkg::POS_CH1_LAST) begin
         acc_ch1 = 14'(acc_ch1 * 10 + d);
         frame_pos++;
      end else if (frame_pos <= spdrd_pkg::POS_CH2_LAST) begin
         acc_ch2 = 14'(acc_ch2 * 10 + d);
         frame_pos++;
      end else if (frame_pos <= spdrd_pkg::POS_ENC_LAST) begin
         phase_digit[frame_pos - spdrd_pkg::POS_ENC_FIRST] = d;
         frame_pos++;
      end else begin
         w.raw_ch1 = acc_ch1;
         w.raw_ch2 = acc_ch2;
         w.mv_ch1 = millivolts(acc_ch1);
         w.mv_ch2 = millivolts(acc_ch2);
         for (int e = 0; e < spdrd_pkg::NUM_ENC; e++) begin
            w.ev[e] = step_encoder(e, phase_digit[e]);
            if (w.ev[e] == spdrd_pkg::ENC_CW) cw_steps++;
            if (w.ev[e] == spdrd_pkg::ENC_CCW) ccw_steps++;
         end
         w.sw = d;
         w.sw_changed = (d != switch_state);
         switch_state = d;
         pending_decodes.push_back(w);
         frame_pos = spdrd_pkg::POS_HUNT;
         acc_ch1 = '0;
         acc_ch2 = '0;
      end
   endtask

   task automatic compare_result();
      decode_word_type want;
      if (pending_decodes.size() == 0) begin
         report_error("result word with no decode pending");
         return;
      end
      want = pending_decodes.pop_front();
      check_field("raw_ch1", rsp_raw_ch1, want.raw_ch1);
      check_field("raw_ch2", rsp_raw_ch2, want.raw_ch2);
      check_field("volts_ch1_mv", rsp_volts_ch1_mv, want.mv_ch1);
      check_field("volts_ch2_mv", rsp_volts_ch2_mv, want.mv_ch2);
      check_field("enc1_event", rsp_enc1_event, want.ev[0]);
      check_field("enc2_event", rsp_enc2_event, want.ev[1]);
      check_field("enc3_event", rsp_enc3_event, want.ev[2]);
      check_field("switch_value", rsp_switch_value, want.sw);
      check_field("switch_changed", rsp_switch_changed, want.sw_changed);
      check_field("malformed", rsp_malformed, want.malformed);
      words_checked++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_en)
            sync_reg = csr_wdata;
         if (push && !full)
            deframe_byte(req_data_byte);
         if (pop && !empty)
            compare_result();
         if ((push && !full) || (pop && !empty))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      pop_tick <= pop_tick + 8'd1;
      if (pop_tick == 8'd0)
         pop_mode <= pop_mode_type'($urandom_range(0, 3));
      case (pop_mode)
         POP_STEADY:     pop <= 1'b1;
         POP_COIN:       pop <= 1'($urandom_range(0, 1));
         POP_LONG_STALL: pop <= (pop_tick[4:0] >= 5'd20);
         default:        pop <= ($urandom_range(0, 7) == 0);
      endcase
   end

   function automatic logic [7:0] digit_char(input int d);
      return 8'(spdrd_pkg::ASCII_ZERO + d);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      push <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_number(input int v);
      for (int p = 1000; p >= 1; p /= 10)
         send_byte(digit_char((v / p) % 10));
   endtask

   task automatic send_frame(input int ch1, input int ch2, input int e1, input int e2,
                             input int e3, input int sw);
      send_byte(cur_sync);
      send_number(ch1);
      send_number(ch2);
      send_byte(digit_char(e1));
      send_byte(digit_char(e2));
      send_byte(digit_char(e3));
      send_byte(digit_char(sw));
   endtask

   task automatic drain_results();
      push <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_sync(input logic [7:0] v);
      drain_results();
      csr_write_en <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cur_sync = v;
      sync_settings++;
   endtask

   function automatic int pick_reading();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 9999;
         2:       return 4095;
         default: return $urandom_range(0, 9999);
      endcase
   endfunction

   task automatic send_random_frame();
      int         kind;
      int         phase [spdrd_pkg::NUM_ENC];
      int         r;
      int         sw;
      logic [7:0] b;
      int         cw_order [4] = '{1, 0, 2, 3};
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else if (kind < 22) begin
         send_byte(cur_sync);
         repeat ($urandom_range(0, 11)) send_byte(digit_char($urandom_range(0, 9)));
         do b = 8'($urandom_range(0, 255));
         while (b >= spdrd_pkg::ASCII_ZERO && b <= spdrd_pkg::ASCII_NINE);
         send_byte(b);
      end else begin
         // walk each encoder around the clockwise cycle 1,0,2,3 in either direction, hold, or jump at random
         for (int e = 0; e < spdrd_pkg::NUM_ENC; e++) begin
            r = $urandom_range(0, 9);
            if (r <= 3) walk_idx[e] = (walk_idx[e] + 1) % 4;
            else if (r <= 6) walk_idx[e] = (walk_idx[e] + 3) % 4;
            else if (r == 9) walk_idx[e] = $urandom_range(0, 3);
            phase[e] = (r == 8) ? $urandom_range(0, 9) : cw_order[walk_idx[e]];
         end
         sw = ($urandom_range(0, 1) != 0) ? last_sw : $urandom_range(0, 9);
         last_sw = sw;
         send_frame(pick_reading(), pick_reading(), phase[0], phase[1], phase[2], sw);
      end
   endtask

   task automatic run_random(input int n_bytes);
      int stop_at;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at)
         send_random_frame();
   endtask

   task automatic test_directed_frames();
      send_byte(8'h00);
      send_byte(8'hFF);
      // enc1 runs 2,3,1,0 and enc2 runs 1,3,2,0: leading zero patterns
      send_frame(0, 9999, 2, 1, 1, 0);
      send_frame(9999, 0, 3, 3, 0, 9);
      send_frame(4095, 2048, 1, 2, 2, 9);
      send_frame(1, 4094, 0, 0, 3, 5);
      // repeat phases: no history change
      send_frame(1, 4094, 0, 0, 3, 5);
   endtask

   task automatic test_malformed_bytes();
      send_byte(cur_sync);
      send_byte(spdrd_pkg::ASCII_ZERO - 8'd1);
      send_byte(cur_sync);
      repeat (11) send_byte(spdrd_pkg::ASCII_NINE);
      send_byte(spdrd_pkg::ASCII_NINE + 8'd1);
      // sync inside payload is a bad digit and does not restart the frame
      send_byte(cur_sync);
      send_byte(spdrd_pkg::ASCII_ZERO);
      send_byte(cur_sync);
      send_byte(spdrd_pkg::ASCII_ZERO);
      send_frame(1234, 5678, 9, 8, 7, 6);
   endtask

   task automatic test_sync_settings();
      set_sync(8'h00);
      run_random(120);
      set_sync(8'hFF);
      run_random(120);
      set_sync(digit_char(7));
      send_frame(7777, 7070, 7, 7, 7, 7);
      run_random(120);
      set_sync(8'($urandom_range(0, 255)));
      run_random(120);
      set_sync(spdrd_pkg::SYNC_RESET);
   endtask

   task automatic test_random_traffic();
      run_random(1500);
   endtask

   initial begin
      clear_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_malformed_bytes();
      test_sync_settings();
      test_random_traffic();
      drain_results();
      if (pending_decodes.size() != 0)
         report_error($sformatf("%0d decodes never delivered", pending_decodes.size()));
      $display("Sent %0d bytes under %0d sync settings; checked %0d words (%0d malformed)",
               bytes_sent, sync_settings + 1, words_checked, malformed_seen);
      $display("Encoder steps seen: %0d clockwise, %0d counter-clockwise; %0d mismatches",
               cw_steps, ccw_steps, errors);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
